// File: rtl/core/opq_pkg.sv
// Shared types and constants for the ordered process queue.
`timescale 1ns / 1ps

package opq_pkg;

  localparam logic [14:0] MIN_ID_LIMIT = 15'd10000;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_POPMIN = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_NONE = 2'd1,
    STATUS_DUP  = 2'd2,
    STATUS_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] handle;
    logic [14:0] proc_id;
  } in_word_t;

  typedef struct packed {
    logic [15:0] result_handle;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } out_word_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [14:0] id;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: rtl/core/opq_cell.sv
// One storage cell of the queue chain: holds an entry, takes its neighbor's or a new one.
`timescale 1ns / 1ps

module opq_cell
  import opq_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  entry_t    nbr_i,
  input  entry_t    push_i,
  output entry_t    entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      entry_q <= push_i;
    end else if (ctl_i.shift) begin
      entry_q <= nbr_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/core/ordered_process_queue.sv
// Top level of the ordered process queue: sequencer and chain of entry cells.
//
//   Channel | Handshake                          | Word
//   --------+------------------------------------+-----------------------------------
//   in      | in_valid_i / in_ready_o            | opcode, handle, proc_id
//   out     | out_valid_o / out_ready_i          | result_handle, status, occupancy
//
// A pop, an unknown opcode, or any operation on an empty table skips the scan. Add,
// remove and lookup scan the n entries held once; pop-min scans them twice when it finds an id.
// The scan rotates the chain one entry per cycle past its head cell.
// Reset clears the entry count and the sequencer registers; the cells are never cleared.
// A result waits in the output register; a new word is accepted meanwhile, and the
// sequencer holds its final step until that register is free.
`timescale 1ns / 1ps

module ordered_process_queue
  import opq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e          state_q, state_d;
  logic [2:0]      op_q, op_d;
  logic [15:0]     hdl_q, hdl_d;
  logic [14:0]     id_q, id_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   k_q, k_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [14:0]     best_q, best_d;
  logic [15:0]     res_q, res_d;
  logic            found_q, found_d;
  logic            pass_q, pass_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;

  logic            shift;
  logic            push;
  logic            drop;
  logic [CW-1:0]   wr_cnt;
  logic [IW-1:0]   wr_ptr;
  logic [CW-1:0]   cnt_n;
  logic [31:0]     occ_ext;
  status_e         st;
  logic [15:0]     rh;
  entry_t          push_entry;
  entry_t          head;
  entry_t          cell_q   [DEPTH];
  entry_t          cell_nbr [DEPTH];
  cell_ctl_t       cell_ctl [DEPTH];

  assign push_entry = (state_q == ST_SCAN) ? head : '{handle: hdl_q, id: id_q};
  assign head       = cell_q[0];
  assign wr_ptr     = wr_cnt[IW-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    if (i == DEPTH - 1) begin : g_tail
      assign cell_nbr[i] = push_entry;
    end else begin : g_body
      assign cell_nbr[i] = cell_q[i+1];
    end
    assign cell_ctl[i] = '{shift: shift, load: push && (wr_ptr == IW'(i))};
    opq_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .nbr_i   (cell_nbr[i]),
      .push_i  (push_entry),
      .entry_o (cell_q[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    hdl_d       = hdl_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    k_d         = k_q;
    pos_d       = pos_q;
    best_d      = best_q;
    res_d       = res_q;
    found_d     = found_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    shift       = 1'b0;
    push        = 1'b0;
    drop        = 1'b0;
    wr_cnt      = cnt_q;
    cnt_n       = cnt_q;
    st          = STATUS_NONE;
    rh          = '0;
    occ_ext     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.opcode;
          hdl_d   = in_data_i.handle;
          id_d    = in_data_i.proc_id;
          n_d     = cnt_q;
          k_d     = '0;
          pos_d   = '0;
          best_d  = MIN_ID_LIMIT;
          res_d   = '0;
          found_d = 1'b0;
          pass_d  = 1'b0;
          if (cnt_q == '0 || in_data_i.opcode == OP_POP || in_data_i.opcode > OP_POPMIN) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        shift = 1'b1;
        case (op_q)
          OP_ADD: begin
            if (head.handle == hdl_q) begin
              found_d = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (head.handle == hdl_q && !found_q) begin
              drop    = 1'b1;
              found_d = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (head.id == id_q && !found_q) begin
              found_d = 1'b1;
              res_d   = head.handle;
            end
          end
          OP_POPMIN: begin
            if (!pass_q) begin
              if (head.id < best_q) begin
                best_d  = head.id;
                pos_d   = k_q;
                found_d = 1'b1;
                res_d   = head.handle;
              end
            end else if (k_q == pos_q) begin
              drop = 1'b1;
            end
          end
          default: begin
          end
        endcase
        push   = !drop;
        wr_cnt = cnt_q - ONE_C;
        if (drop) begin
          cnt_d = cnt_q - ONE_C;
        end
        if (k_q == n_q - ONE_C) begin
          k_d = '0;
          if (op_q == OP_POPMIN && !pass_q && found_d) begin
            pass_d = 1'b1;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          k_d = k_q + ONE_C;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          case (op_q)
            OP_ADD: begin
              if (found_q) begin
                st = STATUS_DUP;
              end else if (cnt_q == DEPTH_C) begin
                st = STATUS_FULL;
              end else begin
                push  = 1'b1;
                cnt_n = cnt_q + ONE_C;
                st    = STATUS_DONE;
              end
            end
            OP_POP: begin
              if (cnt_q != '0) begin
                shift = 1'b1;
                rh    = head.handle;
                cnt_n = cnt_q - ONE_C;
                st    = STATUS_DONE;
              end
            end
            OP_REMOVE: begin
              if (found_q) begin
                st = STATUS_DONE;
              end
            end
            OP_LOOKUP, OP_POPMIN: begin
              if (found_q) begin
                rh = res_q;
                st = STATUS_DONE;
              end
            end
            default: begin
            end
          endcase
          cnt_d       = cnt_n;
          occ_ext     = 32'(cnt_n);
          out_d       = '{result_handle: rh, status: st, occupancy: occ_ext[4:0]};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= '0;
      hdl_q       <= '0;
      id_q        <= '0;
      n_q         <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      best_q      <= '0;
      res_q       <= '0;
      found_q     <= 1'b0;
      pass_q      <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      hdl_q       <= hdl_d;
      id_q        <= id_d;
      n_q         <= n_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      best_q      <= best_d;
      res_q       <= res_d;
      found_q     <= found_d;
      pass_q      <= pass_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the ordered process queue with a scoreboard and random traffic.
`timescale 1ns / 1ps

module testbench;
  import opq_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_WORDS = 750;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} burst_mode_e;

  class opq_scoreboard;
    entry_t    entries[$];
    out_word_t expected_q[$];
    int        failures;
    int        words_checked;
    int        status_seen[4];
    int        peak_fill;

    function void note_word(in_word_t w);
      out_word_t r;
      int pos;
      int best;
      entry_t e;
      r.result_handle = '0;
      r.status = STATUS_NONE;
      pos = -1;
      case (w.opcode)
        OP_ADD: begin
          foreach (entries[k]) if (pos < 0 && entries[k].handle == w.handle) pos = k;
          if (pos >= 0) begin
            r.status = STATUS_DUP;
          end else if (entries.size() >= TABLE_DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            e.handle = w.handle;
            e.id = w.proc_id;
            entries.push_back(e);
            r.status = STATUS_DONE;
          end
        end
        OP_POP: begin
          if (entries.size() > 0) begin
            r.result_handle = entries[0].handle;
            void'(entries.pop_front());
            r.status = STATUS_DONE;
          end
        end
        OP_REMOVE: begin
          foreach (entries[k]) if (pos < 0 && entries[k].handle == w.handle) pos = k;
          if (pos >= 0) begin
            entries.delete(pos);
            r.status = STATUS_DONE;
          end
        end
        OP_LOOKUP: begin
          foreach (entries[k]) if (pos < 0 && entries[k].id == w.proc_id) pos = k;
          if (pos >= 0) begin
            r.result_handle = entries[pos].handle;
            r.status = STATUS_DONE;
          end
        end
        OP_POPMIN: begin
          best = int'(MIN_ID_LIMIT);
          foreach (entries[k]) begin
            if (int'(entries[k].id) < best) begin
              best = int'(entries[k].id);
              pos = k;
            end
          end
          if (pos >= 0) begin
            r.result_handle = entries[pos].handle;
            entries.delete(pos);
            r.status = STATUS_DONE;
          end
        end
        default: begin
        end
      endcase
      r.occupancy = 5'(entries.size());
      if (entries.size() > peak_fill) peak_fill = entries.size();
      status_seen[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_q.size() == 0) begin
        if (failures < 10) $display("Unexpected result word %h", got);
        failures++;
        return;
      end
      exp_w = expected_q.pop_front();
      words_checked++;
      if (got.result_handle !== exp_w.result_handle || got.status !== exp_w.status ||
          got.occupancy !== exp_w.occupancy) begin
        if (failures < 10) begin
          $display("Mismatch on word %0d: handle %h/%h status %0d/%0d occupancy %0d/%0d",
                   words_checked, exp_w.result_handle, got.result_handle, exp_w.status,
                   got.status, exp_w.occupancy, got.occupancy);
        end
        failures++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  opq_scoreboard sb;
  int results_seen;

  ordered_process_queue #(
    .DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words outstanding", sb.expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_word_t mk(logic [2:0] op, logic [15:0] h, logic [14:0] id);
    in_word_t w;
    w.opcode = op;
    w.handle = h;
    w.proc_id = id;
    return w;
  endfunction

  function automatic logic [15:0] pick_handle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 && sb.entries.size() > 0) begin
      return sb.entries[$urandom_range(0, sb.entries.size() - 1)].handle;
    end
    if (sel < 5) return 16'($urandom_range(0, 7));
    if (sel < 6) return 16'hFFFF - 16'($urandom_range(0, 7));
    return 16'($urandom());
  endfunction

  function automatic logic [14:0] pick_id();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2 && sb.entries.size() > 0) begin
      return sb.entries[$urandom_range(0, sb.entries.size() - 1)].id;
    end
    if (sel < 5) return 15'($urandom_range(0, 7));
    if (sel < 7) return 15'($urandom_range(9995, 10005));
    return 15'($urandom());
  endfunction

  function automatic in_word_t make_word(burst_mode_e mode);
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: op = (r < 85) ? OP_ADD : (r < 90) ? OP_POP : (r < 95) ? OP_LOOKUP : OP_POPMIN;
      MODE_DRAIN: op = (r < 35) ? OP_POP : (r < 70) ? OP_POPMIN : (r < 85) ? OP_REMOVE : OP_ADD;
      MODE_MIXED: op = 3'($urandom_range(OP_ADD, OP_POPMIN));
      default: begin
        op = (r < 30) ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)) : 3'($urandom());
        return mk(op, 16'($urandom()), 15'($urandom()));
      end
    endcase
    return mk(op, pick_handle(), pick_id());
  endfunction

  task automatic send_word(in_word_t w, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  task automatic send_idle(in_word_t w);
    send_word(w, $urandom_range(0, 6));
  endtask

  initial begin
    int stall;
    bit fast;
    out_ready_i = 1'b0;
    fast = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = fast ? 0 : $urandom_range(0, 6);
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_word(out_data_o);
      results_seen++;
      if ($urandom_range(0, 15) == 0) fast = !fast;
    end
  end

  initial begin
    int random_sent;
    int len;
    int m;
    bit quick;
    burst_mode_e mode;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    random_sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle(mk(OP_POP, 16'h0000, 15'h0000));
    send_idle(mk(OP_POPMIN, 16'hFFFF, 15'h7FFF));
    send_idle(mk(OP_SPARE_HI, 16'hFFFF, 15'h7FFF));
    send_idle(mk(OP_SPARE_LO, 16'h0000, 15'h0000));
    send_idle(mk(OP_ADD, 16'h0000, 15'h0000));
    send_idle(mk(OP_ADD, 16'hFFFF, 15'h7FFF));
    send_idle(mk(OP_ADD, 16'h0000, 15'd5));
    send_idle(mk(OP_ADD, 16'h1234, 15'd9999));
    send_idle(mk(OP_ADD, 16'h2222, 15'd10000));
    send_idle(mk(OP_ADD, 16'h3333, 15'd9999));
    send_idle(mk(OP_LOOKUP, 16'h0000, 15'h7FFF));
    send_idle(mk(OP_LOOKUP, 16'h0000, 15'd9999));
    send_idle(mk(OP_LOOKUP, 16'hFFFF, 15'd1));
    send_idle(mk(OP_POPMIN, 16'h0000, 15'h0000));
    send_idle(mk(OP_POPMIN, 16'h0000, 15'h0000));
    send_idle(mk(OP_REMOVE, 16'hBEEF, 15'h0000));
    send_idle(mk(OP_REMOVE, 16'hFFFF, 15'h0000));
    send_idle(mk(OP_POPMIN, 16'h0000, 15'h0000));
    send_idle(mk(OP_POPMIN, 16'h0000, 15'h0000));
    send_idle(mk(OP_POP, 16'h0000, 15'h0000));
    send_idle(mk(OP_POP, 16'h0000, 15'h0000));
    send_idle(mk(OP_REMOVE, 16'h0000, 15'h0000));

    while (random_sent < RANDOM_WORDS) begin
      m = $urandom_range(0, 9);
      mode = (random_sent == 0 || m < 3) ? MODE_FILL : (m < 6) ? MODE_DRAIN :
             (m < 9) ? MODE_MIXED : MODE_NOISE;
      len = (mode == MODE_FILL) ? $urandom_range(20, 40) : $urandom_range(5, 30);
      quick = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        send_word(make_word(mode), quick ? 0 : $urandom_range(0, 6));
        random_sent++;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result words: %0d done, %0d none or empty, %0d duplicate, %0d full.",
             sb.words_checked, sb.status_seen[STATUS_DONE], sb.status_seen[STATUS_NONE],
             sb.status_seen[STATUS_DUP], sb.status_seen[STATUS_FULL]);
    $display("Peak occupancy %0d of %0d, with one output hold-off of %0d cycles; %0d failures.",
             sb.peak_fill, TABLE_DEPTH, HOLD_CYCLES, sb.failures);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: ordered_process_queue.f
rtl/core/opq_pkg.sv
rtl/core/opq_cell.sv
rtl/core/ordered_process_queue.sv
tb/sv/testbench.sv
